[hw/rtl/rgbpwm_pkg.sv]
// shared types, constants and helpers for the rgb led pwm latch driver
package rgbpwm_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int LEVELS_DEF    = 64;
    localparam int DUTY_W        = 8;
    localparam int LEVEL_W       = 8;
    localparam int PROD_W        = 16;
    localparam int CHAN_W        = 5;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic       command;
        logic [2:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_t;

    typedef struct packed {
        logic [2:0] latch_select;
        logic [7:0] latch_byte;
        logic       last;
    } out_t;

    // floor(p / 255) for p below 255 * 256 = 65280
    function automatic logic [DUTY_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        begin
            t = {1'b0, p} + {9'd0, p[PROD_W-1:8]} + 17'd1;
            return t[15:8];
        end
    endfunction

endpackage

[hw/rtl/rgbpwm_ram.sv]
// generic single write port, single read port ram with registered read
module rgbpwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 3,
    parameter int AW    = 2
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/rgb_led_pwm_latch_driver.sv]
// top level of the rgb led pwm latch driver
// Duties live in a small RAM with one row of eight 8-bit duties per latch byte, and a
// row that was never written since reset reads as all zero. A set-colour transaction
// is accepted and then does read-modify-write of the one or two rows that hold the
// LED's three channels, in S_MRG0 and, where needed, S_MRG1; one whose LED index is
// not below LED_COUNT is dropped in its accept cycle. A tick transaction reads the
// rows in order and produces one latch byte per cycle while the result side does not
// stall, each byte formed from the RAM read issued for its row. The block works on
// one transaction at a time.
module rgb_led_pwm_latch_driver #(
    parameter int LED_COUNT = rgbpwm_pkg::LED_COUNT_DEF,
    parameter int LEVELS    = rgbpwm_pkg::LEVELS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rgbpwm_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rgbpwm_pkg::out_t m_data
);

    import rgbpwm_pkg::*;

    localparam int CHANNELS = LED_COUNT * 3;
    localparam int ROWS     = (CHANNELS + 7) / 8;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_W    = 8 * DUTY_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MRG0 = 2'd1;
    localparam logic [1:0] S_MRG1 = 2'd2;
    localparam logic [1:0] S_TOUT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [ROWS-1:0]    row_valid_reg, row_valid_next;
    logic               rd_valid_reg;
    logic [ROW_AW-1:0]  byte_idx_reg, byte_idx_next;
    logic [2:0]         led_reg;
    logic [PROD_W-1:0]  prod_reg [3];
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic               re, we;
    logic [ROW_AW-1:0]  raddr, waddr;
    logic [ROW_W-1:0]   rdata, rdata_eff, wdata;

    logic [CHAN_W-1:0]  s_k0, k0, k2;
    logic [ROW_AW-1:0]  s_row0, row0, row1, cur_row;
    logic [DUTY_W-1:0]  duty [3];
    logic [7:0]         tick_byte;
    logic               load_ok, is_last;
    logic               s_fire, led_ok;

    rgbpwm_ram #(
        .WIDTH(ROW_W),
        .DEPTH(ROWS),
        .AW   (ROW_AW)
    ) u_duty_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign led_ok  = ({1'b0, s_data.led_index} < 4'(LED_COUNT));

    assign s_k0   = {2'b00, s_data.led_index} + {1'b0, s_data.led_index, 1'b0};
    assign s_row0 = ROW_AW'(s_k0 >> 3);
    assign k0     = {2'b00, led_reg} + {1'b0, led_reg, 1'b0};
    assign k2     = k0 + 5'd2;
    assign row0   = ROW_AW'(k0 >> 3);
    assign row1   = ROW_AW'(k2 >> 3);
    assign cur_row = (state_reg == S_MRG1) ? row1 : row0;

    assign rdata_eff = rd_valid_reg ? rdata : '0;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            duty[c] = div255(prod_reg[c]);
        end
    end

    // merge the three new duties into the row just read
    always_comb begin
        logic [CHAN_W-1:0] k;
        wdata = rdata_eff;
        for (int j = 0; j < 8; j++) begin
            k = CHAN_W'({cur_row, 3'b000}) + CHAN_W'(j);
            if (k == k0) begin
                wdata[j*DUTY_W +: DUTY_W] = duty[0];
            end else if (k == k0 + 5'd1) begin
                wdata[j*DUTY_W +: DUTY_W] = duty[1];
            end else if (k == k2) begin
                wdata[j*DUTY_W +: DUTY_W] = duty[2];
            end
        end
    end

    // compare the current level against each duty of the row
    always_comb begin
        logic [CHAN_W-1:0] k;
        tick_byte = '0;
        for (int j = 0; j < 8; j++) begin
            k = CHAN_W'({byte_idx_reg, 3'b000}) + CHAN_W'(j);
            tick_byte[j] = (k < CHAN_W'(CHANNELS))
                && (level_reg >= rdata_eff[j*DUTY_W +: DUTY_W]);
        end
    end

    assign load_ok = !m_valid_reg || m_ready;
    assign is_last = (byte_idx_reg == ROW_AW'(ROWS - 1));

    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        row_valid_next = row_valid_reg;
        byte_idx_next  = byte_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        re             = 1'b0;
        raddr          = '0;
        we             = 1'b0;
        waddr          = cur_row;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_data.command == CMD_TICK) begin
                        re            = 1'b1;
                        raddr         = '0;
                        byte_idx_next = '0;
                        state_next    = S_TOUT;
                    end else if (led_ok) begin
                        re         = 1'b1;
                        raddr      = s_row0;
                        state_next = S_MRG0;
                    end
                end
            end
            S_MRG0: begin
                we                    = 1'b1;
                row_valid_next[row0]  = 1'b1;
                if (row1 != row0) begin
                    re         = 1'b1;
                    raddr      = row1;
                    state_next = S_MRG1;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_MRG1: begin
                we                   = 1'b1;
                row_valid_next[row1] = 1'b1;
                state_next           = S_IDLE;
            end
            S_TOUT: begin
                if (load_ok) begin
                    m_valid_next             = 1'b1;
                    m_data_next.latch_select = 3'(byte_idx_reg);
                    m_data_next.latch_byte   = tick_byte;
                    m_data_next.last         = is_last;
                    if (is_last) begin
                        if ({1'b0, level_reg} + 9'd1 >= 9'(LEVELS)) begin
                            level_next = '0;
                        end else begin
                            level_next = level_reg + 8'd1;
                        end
                        state_next = S_IDLE;
                    end else begin
                        byte_idx_next = byte_idx_reg + ROW_AW'(1);
                        re            = 1'b1;
                        raddr         = byte_idx_reg + ROW_AW'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            byte_idx_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            row_valid_reg <= row_valid_next;
            byte_idx_reg  <= byte_idx_next;
            m_valid_reg   <= m_valid_next;
            if (re) begin
                rd_valid_reg <= row_valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_fire) begin
            led_reg     <= s_data.led_index;
            prod_reg[0] <= PROD_W'(LEVELS) * PROD_W'(s_data.red);
            prod_reg[1] <= PROD_W'(LEVELS) * PROD_W'(s_data.green);
            prod_reg[2] <= PROD_W'(LEVELS) * PROD_W'(s_data.blue);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[test/tb.sv]
// testbench for the rgb led pwm latch driver: directed table, random traffic, latch byte checks
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbpwm_pkg::*;

    localparam int LEDS        = LED_COUNT_DEF;
    localparam int LVLS        = LEVELS_DEF;
    localparam int CHANNELS    = LEDS * 3;
    localparam int LATCH_BYTES = (CHANNELS + 7) / 8;
    localparam int RAND_ITEMS  = 450;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        in_t         item;
        logic        typed;
        logic [23:0] bytes;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    logic [7:0] duty_mem [CHANNELS];
    logic [7:0] pwm_level;
    out_t       latch_q [$];
    dir_row_t   dir_rows [$];
    out_t       want;

    int errors       = 0;
    int items_sent   = 0;
    int ticks_sent   = 0;
    int sets_sent    = 0;
    int results_seen = 0;
    int level_wraps  = 0;
    int idle_cycles  = 0;
    bit hold_done    = 0;

    rgb_led_pwm_latch_driver #(
        .LED_COUNT(LEDS),
        .LEVELS   (LVLS)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic logic [7:0] duty_of(input logic [7:0] v);
        int p;
        p = (LVLS * int'(v)) / 255;
        return p[7:0];
    endfunction

    function automatic dir_row_t mk_row(input logic cmd, input logic [2:0] led,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic typed,
                                        input logic [23:0] bytes);
        dir_row_t row;
        row.item.command   = cmd;
        row.item.led_index = led;
        row.item.red       = r;
        row.item.green     = g;
        row.item.blue      = b;
        row.typed          = typed;
        row.bytes          = bytes;
        return row;
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // update duties or work out the latch bytes of one tick
    task automatic predict_latches(input in_t item, input logic typed, input logic [23:0] bytes);
        logic [7:0] lb;
        out_t       r;
        int         k;
        if (item.command == CMD_SET) begin
            if (int'(item.led_index) < LEDS) begin
                duty_mem[item.led_index * 3 + 0] = duty_of(item.red);
                duty_mem[item.led_index * 3 + 1] = duty_of(item.green);
                duty_mem[item.led_index * 3 + 2] = duty_of(item.blue);
            end
        end else begin
            for (int b = 0; b < LATCH_BYTES; b++) begin
                lb = 8'd0;
                for (int i = 0; i < 8; i++) begin
                    k = b * 8 + i;
                    if (k < CHANNELS && pwm_level >= duty_mem[k])
                        lb[i] = 1'b1;
                end
                r.latch_select = b[2:0];
                r.latch_byte   = typed ? bytes[b*8 +: 8] : lb;
                r.last         = (b == LATCH_BYTES - 1);
                latch_q.push_back(r);
            end
            if (int'(pwm_level) + 1 >= LVLS) begin
                pwm_level = 8'd0;
                level_wraps++;
            end else begin
                pwm_level = pwm_level + 8'd1;
            end
        end
    endtask

    task automatic send_item(input in_t item, input int gap, input logic typed,
                             input logic [23:0] bytes);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_latches(item, typed, bytes);
        items_sent++;
        if (item.command == CMD_TICK) ticks_sent++;
        else sets_sent++;
        @(negedge aclk);
    endtask

    // result channel checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (latch_q.size() == 0) begin
                $error("unexpected latch transaction select %0d byte %02h last %0d",
                       m_data.latch_select, m_data.latch_byte, m_data.last);
                errors++;
            end else begin
                want = latch_q.pop_front();
                if (m_data.latch_select !== want.latch_select) begin
                    $error("latch_select expected %0d actual %0d",
                           want.latch_select, m_data.latch_select);
                    errors++;
                end
                if (m_data.latch_byte !== want.latch_byte) begin
                    $error("latch_byte expected %02h actual %02h",
                           want.latch_byte, m_data.latch_byte);
                    errors++;
                end
                if (m_data.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, m_data.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAIL rgb_led_pwm_latch_driver");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side stalls
    initial begin
        int  stall;
        bit  burst;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            burst = ((results_seen / 48) % 3) == 2;
            stall = burst ? 0 : $urandom_range(0, 13);
            if (!hold_done && results_seen >= 90) begin
                stall     = HOLD_CYCLES;
                hold_done = 1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        in_t item;
        int  gap;
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        for (int i = 0; i < CHANNELS; i++) duty_mem[i] = 8'd0;
        pwm_level = 8'd0;

        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'd0,   8'd0,   8'd0,   1'b1, 24'hffffff));
        dir_rows.push_back(mk_row(CMD_SET,  3'd0, 8'd255, 8'd255, 8'd255, 1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'd0,   8'd0,   8'd0,   1'b1, 24'hfffff8));
        dir_rows.push_back(mk_row(CMD_SET,  3'd7, 8'd255, 8'd0,   8'd255, 1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'd0,   8'd0,   8'd0,   1'b1, 24'h5ffff8));
        dir_rows.push_back(mk_row(CMD_SET,  3'd2, 8'd1,   8'd128, 8'd254, 1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_SET,  3'd5, 8'd0,   8'd4,   8'd3,   1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'd0,   8'd0,   8'd0,   1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_SET,  3'd3, 8'd127, 8'd64,  8'd200, 1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_SET,  3'd1, 8'd254, 8'd1,   8'd255, 1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_SET,  3'd4, 8'd255, 8'd255, 8'd0,   1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_SET,  3'd6, 8'd0,   8'd255, 8'd128, 1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'd0,   8'd0,   8'd0,   1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd7, 8'd255, 8'd255, 8'd255, 1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd5, 8'd170, 8'd85,  8'd15,  1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_SET,  3'd0, 8'd0,   8'd0,   8'd0,   1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_SET,  3'd7, 8'd0,   8'd0,   8'd0,   1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'd0,   8'd0,   8'd0,   1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_SET,  3'd2, 8'd255, 8'd255, 8'd255, 1'b0, 24'h0));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd2, 8'd0,   8'd0,   8'd0,   1'b0, 24'h0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, $urandom_range(0, 3), dir_rows[i].typed,
                      dir_rows[i].bytes);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 150) begin
                s_valid <= 1'b0;
                while (latch_q.size() != 0) @(posedge aclk);
                @(negedge aclk);
            end
            item.command   = $urandom_range(0, 1) ? CMD_TICK : CMD_SET;
            item.led_index = 3'($urandom_range(0, 7));
            item.red       = pick_level();
            item.green     = pick_level();
            item.blue      = pick_level();
            gap = (((n / 40) % 3) == 1) ? 0 : $urandom_range(0, 13);
            send_item(item, gap, 1'b0, 24'h0);
        end
        s_valid <= 1'b0;

        while (latch_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("sent %0d transactions (%0d ticks, %0d colour sets), checked %0d latch bytes",
                 items_sent, ticks_sent, sets_sent, results_seen);
        $display("pwm level counter wrapped %0d times, long result-side hold-off applied: %0d",
                 level_wraps, hold_done);
        if (errors == 0 && latch_q.size() == 0) begin
            $display("PASS rgb_led_pwm_latch_driver");
        end else begin
            $display("FAIL rgb_led_pwm_latch_driver");
        end
        $finish;
    end

endmodule
